FILE: rtl/assert_macros.svh
// assertion macros used by the scheduler top level
// depends on a clock named clk and a reset named rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/tlls_pkg.sv
// types, codes and constants of the two-level lottery scheduler
// no dependencies
`default_nettype none
package tlls_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int TICK_W    = 8;
  localparam int RUN_W     = 32;
  localparam int SEED_W    = 22;
  localparam int DIVD_W    = 22;
  localparam int DIVS_W    = 22;
  localparam logic [6:0]        LCG_MULT  = 7'd125;
  // modulus is (2^23 + 1) / 3, so 2^23 folds to -1 modulo it
  localparam logic [DIVS_W-1:0] LCG_MOD   = 22'd2796203;
  localparam logic [SEED_W-1:0] SEED_INIT = 22'd100001;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_SETRUN  = 3'd1,
    ACT_FREE    = 3'd2,
    ACT_PICK    = 3'd3,
    ACT_RUNDONE = 3'd4,
    ACT_STATS   = 3'd5
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_STAT, ST_TOT, ST_MUL, ST_MOD1, ST_MOD2, ST_WALK, ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] slot;
    logic [7:0] ticket_count;
    logic       runnable_flag;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  winner_slot;
    logic        winner_level;
    logic        slot_used;
    logic        slot_level;
    logic [31:0] high_runs;
    logic [31:0] low_runs;
  } rsp_t;

  typedef struct packed {
    logic [TICK_W-1:0] tickets;
    logic [RUN_W-1:0]  high_runs;
    logic [RUN_W-1:0]  low_runs;
  } ent_t;

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    sat_inc = (v == {RUN_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tlls_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none
module tlls_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output      logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tlls_mod.sv
// iterative restoring remainder unit, one dividend bit per cycle
// depends on tlls_pkg
`default_nettype none
module tlls_mod (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tlls_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [tlls_pkg::DIVS_W-1:0]   divisor,
  output      logic                          done,
  output      logic [tlls_pkg::DIVS_W-1:0]   rem
);
  import tlls_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DIVD_W-1:0]   quo;
  logic [DIVS_W-1:0]   r;
  logic [DIVS_W-1:0]   d;
  logic [DIVS_W:0]     trial;

  assign trial = {r, quo[DIVD_W-1]};
  assign rem   = r;

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
        quo  <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        quo <= quo << 1;
        cnt <= cnt - 1'b1;
        if (trial >= {1'b0, d}) begin
          r <= DIVS_W'(trial - {1'b0, d});
        end else begin
          r <= DIVS_W'(trial);
        end
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/two_level_lottery_scheduler.sv
// top level of the two-level lottery scheduler: control, slot flags, result register
// depends on tlls_pkg, tlls_ram, tlls_mod, assert_macros.svh
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | tlls_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_ready  | tlls_pkg::rsp_t
//
// one request at a time; allocate, set runnable, free and run done pass through the
// exec and resp states, read stats of a slot in the table also through the stat state,
// plus any wait for the result register to drain. a pick consists of at most two
// passes over the slot ram through its single read port, a folded lcg step and one
// remainder run; a pick with nothing runnable ends after the first pass.
// reset clears flags and counters-valid bits at once; no clearing pass.
// a new request is taken while the previous result waits in the output register.
`default_nettype none
module two_level_lottery_scheduler #(
  parameter int SLOTS = tlls_pkg::SLOTS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_ready,
  input  wire tlls_pkg::req_t  req,
  output      logic            rsp_valid,
  input  wire logic            rsp_ready,
  output      tlls_pkg::rsp_t  rsp
);
  import tlls_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int SW = $clog2(SLOTS * 255 + 1);
  localparam logic [SEED_W+1:0] MOD_X1 = (SEED_W+2)'(LCG_MOD);
  localparam logic [SEED_W+1:0] MOD_X2 = {MOD_X1[SEED_W:0], 1'b0};

  state_t state, state_next;

  logic [SLOTS-1:0] used_bits, run_bits, level_bits, cnt_valid;
  req_t             req_q;
  rsp_t             res;
  logic [SEED_W-1:0] seed;
  logic [IW-1:0]    last_winner;
  logic             last_level;
  logic [CW-1:0]    cnt;
  logic             d_vld;
  logic [IW-1:0]    d_idx;
  logic [SW-1:0]    hi_sum, lo_sum, total, draw, w_sum;
  logic             lvl;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  ent_t             ram_wdata, ram_rdata;
  logic             mod_start, mod_done;
  logic [DIVD_W-1:0] mod_dividend;
  logic [DIVS_W-1:0] mod_divisor, mod_rem;

  logic             in_table, out_free, elig_d, hit, tot_last, more;
  logic [IW-1:0]    c_idx;
  logic [SW-1:0]    hi_n, lo_n, walk_sum;
  logic [TICK_W-1:0] hi_add, lo_add;

  logic [SEED_W+6:0] lcg_prod;
  logic [SEED_W+1:0] lcg_fold, lcg_fold_n, lcg_red1, lcg_red2;

  tlls_ram #(.W($bits(ent_t)), .D(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tlls_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // decode of the held request and scan helpers
  assign c_idx    = IW'(req_q.slot);
  assign in_table = 32'(req_q.slot) < 32'(SLOTS);
  assign out_free = !rsp_valid || rsp_ready;
  assign more     = cnt < CW'(SLOTS);
  assign elig_d   = used_bits[d_idx] && run_bits[d_idx] && (level_bits[d_idx] == lvl);
  assign hi_add   = (used_bits[d_idx] && run_bits[d_idx] && level_bits[d_idx])
                    ? ram_rdata.tickets : '0;
  assign lo_add   = (used_bits[d_idx] && run_bits[d_idx] && !level_bits[d_idx])
                    ? ram_rdata.tickets : '0;
  assign hi_n     = hi_sum + SW'(hi_add);
  assign lo_n     = lo_sum + SW'(lo_add);
  assign tot_last = d_vld && (d_idx == IW'(SLOTS - 1));
  assign walk_sum = w_sum + SW'(ram_rdata.tickets);
  assign hit      = d_vld && elig_d && (walk_sum >= draw);

  // lcg step: fold bits above 2^23 back as a subtraction, then two conditional subtracts
  assign lcg_prod   = (SEED_W+7)'(seed) * (SEED_W+7)'(LCG_MULT);
  assign lcg_fold_n = (SEED_W+2)'(lcg_prod[SEED_W:0]) + MOD_X1
                      - (SEED_W+2)'(lcg_prod[SEED_W+6:SEED_W+1]);
  assign lcg_red1   = (lcg_fold >= MOD_X2) ? lcg_fold - MOD_X2 : lcg_fold;
  assign lcg_red2   = (lcg_red1 >= MOD_X1) ? lcg_red1 - MOD_X1 : lcg_red1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, ram and remainder unit control
  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cnt[IW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = d_idx;
    ram_wdata    = ram_rdata;
    mod_start    = 1'b0;
    mod_dividend = lcg_red2[DIVD_W-1:0];
    mod_divisor  = DIVS_W'(total);
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
        case (req_q.action)
          ACT_ALLOC: begin
            ram_waddr         = c_idx;
            ram_wdata.tickets = (req_q.ticket_count == '0) ? TICK_W'(1) : req_q.ticket_count;
            ram_wdata.high_runs = '0;
            ram_wdata.low_runs  = '0;
            ram_we            = in_table && !used_bits[c_idx];
          end
          ACT_STATS: begin
            if (in_table) begin
              ram_re     = 1'b1;
              ram_raddr  = c_idx;
              state_next = ST_STAT;
            end
          end
          ACT_PICK: state_next = ST_TOT;
          default: ;
        endcase
      end
      ST_STAT: state_next = ST_RESP;
      ST_TOT: begin
        ram_re = more;
        if (tot_last) begin
          state_next = (hi_n != '0 || lo_n != '0) ? ST_MUL : ST_RESP;
        end
      end
      ST_MUL: state_next = ST_MOD1;
      ST_MOD1: begin
        mod_start  = 1'b1;
        state_next = ST_MOD2;
      end
      ST_MOD2: begin
        if (mod_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        ram_re = more;
        if (hit) begin
          ram_we              = 1'b1;
          ram_wdata.high_runs = lvl ? sat_inc(ram_rdata.high_runs) : ram_rdata.high_runs;
          ram_wdata.low_runs  = lvl ? ram_rdata.low_runs : sat_inc(ram_rdata.low_runs);
          state_next          = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // slot flags, lottery state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      used_bits   <= '0;
      run_bits    <= '0;
      level_bits  <= '0;
      cnt_valid   <= '0;
      seed        <= SEED_INIT;
      last_winner <= '0;
      last_level  <= 1'b0;
      rsp_valid   <= 1'b0;
      d_vld       <= 1'b0;
    end else begin
      d_vld <= ram_re;
      d_idx <= ram_raddr;
      if (state == ST_RESP && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            res   <= '0;
          end
        end
        ST_EXEC: begin
          cnt <= '0;
          hi_sum <= '0;
          lo_sum <= '0;
          case (req_q.action)
            ACT_ALLOC: begin
              if (in_table && !used_bits[c_idx]) begin
                used_bits[c_idx]  <= 1'b1;
                run_bits[c_idx]   <= 1'b0;
                level_bits[c_idx] <= 1'b1;
                cnt_valid[c_idx]  <= 1'b1;
                res.ok            <= 1'b1;
              end
            end
            ACT_SETRUN: begin
              if (in_table && used_bits[c_idx]) begin
                run_bits[c_idx] <= req_q.runnable_flag;
                res.ok          <= 1'b1;
              end
            end
            ACT_FREE: begin
              if (in_table && used_bits[c_idx]) begin
                used_bits[c_idx] <= 1'b0;
                run_bits[c_idx]  <= 1'b0;
                res.ok           <= 1'b1;
              end
            end
            ACT_RUNDONE: begin
              if (used_bits[last_winner]) begin
                run_bits[last_winner] <= req_q.runnable_flag;
                if (req_q.runnable_flag && last_level) begin
                  level_bits[last_winner] <= 1'b0;
                end
                res.ok <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_STAT: begin
          res.ok         <= 1'b1;
          res.slot_used  <= used_bits[c_idx];
          res.slot_level <= level_bits[c_idx];
          res.high_runs  <= cnt_valid[c_idx] ? ram_rdata.high_runs : '0;
          res.low_runs   <= cnt_valid[c_idx] ? ram_rdata.low_runs : '0;
        end
        ST_TOT: begin
          if (ram_re) begin
            cnt <= cnt + 1'b1;
          end
          if (d_vld) begin
            hi_sum <= hi_n;
            lo_sum <= lo_n;
          end
          if (tot_last) begin
            lvl   <= (hi_n != '0);
            total <= (hi_n != '0) ? hi_n : lo_n;
          end
        end
        ST_MUL: begin
          lcg_fold <= lcg_fold_n;
        end
        ST_MOD1: begin
          seed <= lcg_red2[SEED_W-1:0];
        end
        ST_MOD2: begin
          if (mod_done) begin
            draw  <= SW'(mod_rem);
            cnt   <= '0;
            w_sum <= '0;
          end
        end
        ST_WALK: begin
          if (ram_re) begin
            cnt <= cnt + 1'b1;
          end
          if (d_vld && elig_d) begin
            w_sum <= walk_sum;
          end
          if (hit) begin
            run_bits[d_idx]  <= 1'b0;
            last_winner      <= d_idx;
            last_level       <= lvl;
            res.ok           <= 1'b1;
            res.winner_slot  <= 6'(d_idx);
            res.winner_level <= lvl;
          end
        end
        default: ;
      endcase
    end
  end

`include "assert_macros.svh"
  // the remainder by the ticket total never sees a zero divisor
  `ASSERT_IMP(a_total_nonzero, state == ST_MOD2, total != '0)
  // the draw lies below the ticket total
  `ASSERT_IMP(a_draw_range, state == ST_WALK, draw < total)
  // a pick only writes back a slot that was eligible
  `ASSERT_IMP(a_walk_write, ram_we && state == ST_WALK, elig_d && d_vld)
  // one request at a time
  `ASSERT_NXT(a_one_req, req_valid && req_ready, !req_ready)
endmodule
`default_nettype wire
